// ===== rtl/spdif_pkg.sv =====
// Shared types, constants and register codes of the S/PDIF frame encoder.
package spdif_pkg;

    localparam int AUDIO_W     = 24;
    localparam int LINE_W      = 64;
    localparam int STATUS_W    = 64;
    localparam int BLOCK_BITS  = 192;
    localparam int POS_W       = 8;
    localparam int DATA_CELLS  = 28;
    localparam int PRE_W       = 8;
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 64;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_BITS - 1);

    // Preamble patterns, indexed by the line level before the preamble.
    localparam logic [PRE_W-1:0] PRE_B_LO = 8'hE8;
    localparam logic [PRE_W-1:0] PRE_B_HI = 8'h17;
    localparam logic [PRE_W-1:0] PRE_M_LO = 8'hE2;
    localparam logic [PRE_W-1:0] PRE_M_HI = 8'h1D;
    localparam logic [PRE_W-1:0] PRE_W_LO = 8'hE4;
    localparam logic [PRE_W-1:0] PRE_W_HI = 8'h1B;

    localparam logic [STATUS_W-1:0] STATUS_LOW_RESET = 64'h0000_000B_0200_0004;

    typedef enum logic [1:0] {
        REG_STATUS_LOW  = 2'd0,
        REG_STATUS_MID  = 2'd1,
        REG_STATUS_HIGH = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [AUDIO_W-1:0] left_audio;
        logic [AUDIO_W-1:0] right_audio;
    } frame_t;

    typedef struct packed {
        logic [LINE_W-1:0] line_bits;
        logic              last;
    } subframe_t;

    // One classified frame as it waits between front and back.
    typedef struct packed {
        logic [AUDIO_W-1:0] left_audio;
        logic [AUDIO_W-1:0] right_audio;
        logic               status_bit;
        logic               block_start;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== rtl/spdif_cfg.sv =====
// Configuration registers holding the 192-bit channel-status block.
module spdif_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [spdif_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [spdif_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [spdif_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready,
    output logic [spdif_pkg::BLOCK_BITS-1:0] status_block
);
    import spdif_pkg::*;

    logic [STATUS_W-1:0] low_reg;
    logic [STATUS_W-1:0] mid_reg;
    logic [STATUS_W-1:0] high_reg;
    logic [1:0]          index;
    logic                write_en;

    assign index    = paddr[CFG_ADDR_W-1:3];
    assign pready   = 1'b1;
    assign write_en = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= STATUS_LOW_RESET;
            mid_reg  <= '0;
            high_reg <= '0;
        end
        else if (write_en)
        begin
            case (index)
                REG_STATUS_LOW:  low_reg  <= pwdata;
                REG_STATUS_MID:  mid_reg  <= pwdata;
                REG_STATUS_HIGH: high_reg <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_STATUS_LOW:  prdata = low_reg;
            REG_STATUS_MID:  prdata = mid_reg;
            REG_STATUS_HIGH: prdata = high_reg;
            default:         prdata = '0;
        endcase
    end

    assign status_block = {high_reg, mid_reg, low_reg};

endmodule

// ===== rtl/spdif_front.sv =====
// Front end: accepts frames, tracks the block position and picks the status bit.
module spdif_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             frame_valid,
    output logic                             frame_stall,
    input  spdif_pkg::frame_t                frame_beat,
    input  logic [spdif_pkg::BLOCK_BITS-1:0] status_block,
    input  spdif_pkg::queue_status_t         queue_status,
    output logic                             push,
    output spdif_pkg::job_t                  push_job
);
    import spdif_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    assign frame_stall = queue_status.full;
    assign push        = frame_valid && !queue_status.full;

    always_comb
    begin
        push_job.left_audio  = frame_beat.left_audio;
        push_job.right_audio = frame_beat.right_audio;
        push_job.block_start = (pos_reg == '0);
        push_job.status_bit  = (pos_reg < POS_W'(BLOCK_BITS)) ? status_block[pos_reg] : 1'b0;
        pos_next = (pos_reg >= LAST_POS) ? '0 : pos_reg + POS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (push)
        begin
            pos_reg <= pos_next;
        end
    end

    a_pos_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("frame position left the status block");

endmodule

// ===== rtl/spdif_queue.sv =====
// Two-entry queue of classified frames between front and back.
module spdif_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  spdif_pkg::job_t          push_job,
    input  logic                     pop,
    output spdif_pkg::job_t          head_job,
    output spdif_pkg::queue_status_t status
);
    import spdif_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign head_job     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full))
        else $error("frame pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && status.empty))
        else $error("frame popped from an empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

// ===== rtl/spdif_back.sv =====
// Back end: biphase-mark encodes one subframe per unstalled cycle into out_reg.
module spdif_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  spdif_pkg::job_t          head_job,
    input  spdif_pkg::queue_status_t queue_status,
    output logic                     pop,
    output logic                     subframe_valid,
    input  logic                     subframe_stall,
    output spdif_pkg::subframe_t     subframe_beat
);
    import spdif_pkg::*;

    logic                  level_reg;
    logic                  right_reg;
    logic                  valid_reg;
    subframe_t             out_reg;
    logic                  advance;
    logic                  fire;
    logic [PRE_W-1:0]      pat;
    logic [AUDIO_W-1:0]    audio;
    logic [DATA_CELLS-1:0] data;
    logic [LINE_W-1:0]     word;
    logic                  level_next;

    // The level before each cell is the preamble's last UI, flipped once per
    // earlier cell and once more for each earlier one bit.
    function automatic logic [LINE_W-1:0] encode(input logic [PRE_W-1:0] p,
                                                 input logic [DATA_CELLS-1:0] d);
        logic [LINE_W-1:0]     w;
        logic [DATA_CELLS-1:0] mask;
        logic                  lvl;
        w = '0;
        for (int i = 0; i < PRE_W; i++)
        begin
            w[i] = p[PRE_W-1-i];
        end
        for (int i = 0; i < DATA_CELLS; i++)
        begin
            mask = (DATA_CELLS'(1) << i) - DATA_CELLS'(1);
            lvl = p[0] ^ 1'(i % 2) ^ (^(d & mask));
            w[PRE_W + 2*i]     = !lvl;
            w[PRE_W + 2*i + 1] = !lvl ^ d[i];
        end
        return w;
    endfunction

    assign advance = !valid_reg || !subframe_stall;
    assign fire    = advance && !queue_status.empty;
    assign pop     = fire && right_reg;

    always_comb
    begin
        if (right_reg)
        begin
            pat = level_reg ? PRE_W_HI : PRE_W_LO;
        end
        else if (head_job.block_start)
        begin
            pat = level_reg ? PRE_B_HI : PRE_B_LO;
        end
        else
        begin
            pat = level_reg ? PRE_M_HI : PRE_M_LO;
        end
        audio = right_reg ? head_job.right_audio : head_job.left_audio;
        data = {(^audio) ^ head_job.status_bit, head_job.status_bit, 2'b00, audio};
        word = encode(pat, data);
        // An even number of cells, so only the count of one bits moves the level.
        level_next = pat[0] ^ (^data);
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg.line_bits <= word;
            out_reg.last      <= right_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            right_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            level_reg <= level_next;
            right_reg <= !right_reg;
            valid_reg <= 1'b1;
        end
        else if (!subframe_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign subframe_valid = valid_reg;
    assign subframe_beat  = out_reg;

    a_last_follows_phase: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (subframe_beat.last == $past(right_reg)))
        else $error("subframe marked with the wrong side");

endmodule

// ===== rtl/spdif_frame_bmc_encoder_unit.sv =====
// Top level of the S/PDIF frame encoder with biphase-mark line coding.
//
//  channel    direction  beat          handshake
//  frame      in         frame_t       frame_valid / frame_stall
//  subframe   out        subframe_t    subframe_valid / subframe_stall
//  config     in         64-bit APB    psel, penable, pwrite, pready
//
// Each frame yields two subframe beats, left then right, one per cycle from
// the encoder's output register while the subframe side does not stall.
// A new frame is taken while earlier ones wait in the two-entry queue.
// Reset clears the queue, the block position and the line level, and loads
// the status registers with their defaults; no clearing pass is needed.
// A stall on the subframe side holds the output beat; frames back up into
// the queue and frame_stall rises once it is full.
module spdif_frame_bmc_encoder_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             frame_valid,
    output logic                             frame_stall,
    input  spdif_pkg::frame_t                frame_beat,
    output logic                             subframe_valid,
    input  logic                             subframe_stall,
    output spdif_pkg::subframe_t             subframe_beat,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [spdif_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [spdif_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [spdif_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready
);
    import spdif_pkg::*;

    logic [BLOCK_BITS-1:0] status_block;
    queue_status_t         queue_status;
    logic                  push;
    logic                  pop;
    job_t                  push_job;
    job_t                  head_job;

    spdif_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .status_block (status_block)
    );

    spdif_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame_beat   (frame_beat),
        .status_block (status_block),
        .queue_status (queue_status),
        .push         (push),
        .push_job     (push_job)
    );

    spdif_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (queue_status)
    );

    spdif_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_job       (head_job),
        .queue_status   (queue_status),
        .pop            (pop),
        .subframe_valid (subframe_valid),
        .subframe_stall (subframe_stall),
        .subframe_beat  (subframe_beat)
    );

endmodule

// ===== verif/spdif_frame_bmc_encoder_checker.sv =====
// Scoreboard that predicts and checks the subframe beats of the S/PDIF frame encoder.
`timescale 1ns / 1ps

module spdif_frame_bmc_encoder_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             frame_valid,
    input  logic                             frame_stall,
    input  spdif_pkg::frame_t                frame_beat,
    input  logic                             subframe_valid,
    input  logic                             subframe_stall,
    input  spdif_pkg::subframe_t             subframe_beat,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [spdif_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [spdif_pkg::CFG_DATA_W-1:0] pwdata,
    output int                               fail_count,
    output int                               pending
);
    import spdif_pkg::*;

    localparam int REPORT_LIMIT = 10;

    subframe_t           expected_subframes[$];
    logic [STATUS_W-1:0] status_low;
    logic [STATUS_W-1:0] status_mid;
    logic [STATUS_W-1:0] status_high;
    logic                line_lvl;
    logic [POS_W-1:0]    frame_pos;

    function automatic logic channel_status_bit(input logic [POS_W-1:0] pos);
        // The low six bits of the position index each 64-bit word directly.
        if (pos < 64)
            return status_low[pos[5:0]];
        else if (pos < 128)
            return status_mid[pos[5:0]];
        else if (pos < BLOCK_BITS)
            return status_high[pos[5:0]];
        return 1'b0;
    endfunction

    // Builds the 64 line UIs of one subframe and advances the line level.
    function automatic logic [LINE_W-1:0] encode_subframe(
        input logic [PRE_W-1:0]   pat_lo,
        input logic [PRE_W-1:0]   pat_hi,
        input logic [AUDIO_W-1:0] audio,
        input logic               cs
    );
        logic [LINE_W-1:0]     word;
        logic [PRE_W-1:0]      pat;
        logic [DATA_CELLS-1:0] cells;
        int                    ui;
        int                    i;

        word = '0;
        pat  = line_lvl ? pat_hi : pat_lo;
        // The preamble goes out most significant bit first.
        for (i = 0; i < PRE_W; i++)
            word[i] = pat[PRE_W-1-i];
        line_lvl = pat[0];
        // Parity, status, user, validity, then the audio bits.
        cells = {(^audio) ^ cs, cs, 1'b0, 1'b0, audio};
        ui = PRE_W;
        for (i = 0; i < DATA_CELLS; i++)
        begin
            line_lvl = ~line_lvl;
            word[ui] = line_lvl;
            if (cells[i])
                line_lvl = ~line_lvl;
            word[ui+1] = line_lvl;
            ui += 2;
        end
        return word;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        subframe_t want;
        subframe_t left_sf;
        subframe_t right_sf;
        logic      cs;

        if (!rst_n)
        begin
            expected_subframes.delete();
            status_low  = STATUS_LOW_RESET;
            status_mid  = '0;
            status_high = '0;
            line_lvl    = 1'b0;
            frame_pos   = '0;
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            // Compare before predicting, so a stray beat cannot match a frame taken now.
            if (subframe_valid && !subframe_stall)
            begin
                if (expected_subframes.size() == 0)
                    note_failure($sformatf("subframe beat with none expected: bits %h last %b",
                                           subframe_beat.line_bits, subframe_beat.last));
                else
                begin
                    want = expected_subframes.pop_front();
                    if (subframe_beat.line_bits !== want.line_bits)
                        note_failure($sformatf("line_bits: expected %h, got %h",
                                               want.line_bits, subframe_beat.line_bits));
                    if (subframe_beat.last !== want.last)
                        note_failure($sformatf("last: expected %b, got %b",
                                               want.last, subframe_beat.last));
                end
            end

            if (frame_valid && !frame_stall)
            begin
                cs = channel_status_bit(frame_pos);
                if (frame_pos == '0)
                    left_sf.line_bits = encode_subframe(PRE_B_LO, PRE_B_HI,
                                                        frame_beat.left_audio, cs);
                else
                    left_sf.line_bits = encode_subframe(PRE_M_LO, PRE_M_HI,
                                                        frame_beat.left_audio, cs);
                left_sf.last = 1'b0;
                right_sf.line_bits = encode_subframe(PRE_W_LO, PRE_W_HI,
                                                     frame_beat.right_audio, cs);
                right_sf.last = 1'b1;
                expected_subframes.push_back(left_sf);
                expected_subframes.push_back(right_sf);
                frame_pos = (frame_pos >= LAST_POS) ? '0 : frame_pos + 1'b1;
            end

            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[CFG_ADDR_W-1:3]))
                    REG_STATUS_LOW:  status_low  = pwdata;
                    REG_STATUS_MID:  status_mid  = pwdata;
                    REG_STATUS_HIGH: status_high = pwdata;
                    default: ;
                endcase
            end

            pending = expected_subframes.size();
        end
    end

endmodule

// ===== verif/spdif_frame_bmc_encoder_unit_tb.sv =====
// Stimulus, clock, reset and verdict for the S/PDIF frame encoder testbench.
`timescale 1ns / 1ps

module spdif_frame_bmc_encoder_unit_tb;
    import spdif_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 6;
    localparam int CHUNKS         = 5;
    localparam int CHUNK_FRAMES   = 50;

    logic                  clk;
    logic                  rst_n;
    logic                  frame_valid;
    logic                  frame_stall;
    frame_t                frame_beat;
    logic                  subframe_valid;
    logic                  subframe_stall;
    subframe_t             subframe_beat;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int gap_odds   = 0;
    int stall_odds = 0;
    int idle_cycles = 0;

    spdif_frame_bmc_encoder_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .frame_beat     (frame_beat),
        .subframe_valid (subframe_valid),
        .subframe_stall (subframe_stall),
        .subframe_beat  (subframe_beat),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    spdif_frame_bmc_encoder_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .frame_beat     (frame_beat),
        .subframe_valid (subframe_valid),
        .subframe_stall (subframe_stall),
        .subframe_beat  (subframe_beat),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Any accepted beat or register write counts as progress.
    always @(posedge clk)
    begin
        if ((frame_valid && !frame_stall) || (subframe_valid && !subframe_stall)
            || (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("spdif_frame_bmc_encoder_unit_tb failed");
            $finish;
        end
    end

    // Receiver back-pressure in bursts.
    initial
    begin
        subframe_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds)
            begin
                subframe_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            subframe_stall <= 1'b0;
        end
    end

    function automatic logic [AUDIO_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return AUDIO_W'($urandom);
        endcase
    endfunction

    function automatic int pick_odds(input bit allowed);
        if (!allowed)
            return 0;
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 25;
            default: return 60;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_frame(input logic [AUDIO_W-1:0] left, input logic [AUDIO_W-1:0] right);
        if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds)
        begin
            frame_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        frame_beat  <= '{left_audio: left, right_audio: right};
        frame_valid <= 1'b1;
        do
            @(posedge clk);
        while (frame_stall);
        @(negedge clk);
    endtask

    task automatic write_status(input reg_index_t idx, input logic [STATUS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        frame_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int p;
        int c;

        rst_n          = 1'b0;
        frame_valid    = 1'b0;
        frame_beat     = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Field extremes, single set bits and parity patterns at the reset status block.
        send_frame(24'h000000, 24'h000000);
        send_frame(24'hFFFFFF, 24'hFFFFFF);
        send_frame(24'h000000, 24'hFFFFFF);
        send_frame(24'hFFFFFF, 24'h000000);
        send_frame(24'h000001, 24'h800000);
        send_frame(24'h800000, 24'h000001);
        send_frame(24'hAAAAAA, 24'h555555);
        send_frame(24'h555555, 24'hAAAAAA);
        send_frame(24'h000003, 24'h000007);
        send_frame(24'hFFFFFE, 24'h7FFFFF);
        send_frame(24'h0F0F0F, 24'hF0F0F0);
        send_frame(24'h123456, 24'hEDCBA9);
        send_frame(24'h000000, 24'h000001);
        send_frame(24'h000001, 24'h000000);
        send_frame(24'hFFFFFF, 24'hFFFFFE);
        send_frame(24'h7FFFFF, 24'h800001);

        for (p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    write_status(REG_STATUS_LOW, '1);
                    write_status(REG_STATUS_MID, '1);
                    write_status(REG_STATUS_HIGH, '1);
                end
                1:
                begin
                    write_status(REG_STATUS_LOW, '0);
                    write_status(REG_STATUS_MID, '0);
                    write_status(REG_STATUS_HIGH, '0);
                end
                PHASES - 1:
                begin
                    write_status(REG_STATUS_LOW, 64'h5555_5555_5555_5555);
                    write_status(REG_STATUS_MID, 64'hAAAA_AAAA_AAAA_AAAA);
                    write_status(REG_STATUS_HIGH, {$urandom, $urandom});
                end
                default:
                begin
                    write_status(REG_STATUS_LOW, {$urandom, $urandom});
                    write_status(REG_STATUS_MID, {$urandom, $urandom});
                    write_status(REG_STATUS_HIGH, {$urandom, $urandom});
                end
            endcase

            // The final phase runs at full rate on both sides.
            for (c = 0; c < CHUNKS; c++)
            begin
                gap_odds   = pick_odds(p != 2 && p != PHASES - 1);
                stall_odds = pick_odds(p != 1 && p != PHASES - 1);
                repeat (CHUNK_FRAMES) send_frame(random_sample(), random_sample());
            end
        end

        drain();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("spdif_frame_bmc_encoder_unit_tb passed");
        else
            $display("spdif_frame_bmc_encoder_unit_tb failed");
        $finish;
    end

endmodule

// ===== spdif_frame_bmc_encoder_unit.f =====
rtl/spdif_pkg.sv
rtl/spdif_cfg.sv
rtl/spdif_front.sv
rtl/spdif_queue.sv
rtl/spdif_back.sv
rtl/spdif_frame_bmc_encoder_unit.sv
verif/spdif_frame_bmc_encoder_checker.sv
verif/spdif_frame_bmc_encoder_unit_tb.sv
